### hdl/dim_pkg.sv
// shared constants and controller/datapath command and status types
// for the disjoint interval merge table; no dependencies
package dim_pkg;

  localparam int MAX_RANGES = 32;
  localparam int VALUE_BITS = 16;
  localparam int TOTAL_W    = 6;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 2);
  localparam int MEM_DEPTH  = 2 << IDX_W;

  typedef struct packed {
    logic load;
    logic add_step;
    logic add_finish;
    logic list_step;
    logic list_empty;
  } dim_cmd_t;

  typedef struct packed {
    logic at_end;
    logic at_last;
    logic empty;
  } dim_sts_t;

endpackage

### hdl/dim_ctrl.sv
// sequencing state machine for the disjoint interval merge table
// depends on dim_pkg for the command and status types
module dim_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_func,
  input  dim_pkg::dim_sts_t  sts,
  output dim_pkg::dim_cmd_t  cmd,
  output logic               busy
);
  import dim_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_LIST
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = in_func ? S_LIST : S_ADD;
        end
      end
      S_ADD: begin
        if (sts.at_end) begin
          cmd.add_finish = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.add_step = 1'b1;
        end
      end
      S_LIST: begin
        if (sts.empty) begin
          cmd.list_empty = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.list_step = 1'b1;
          if (sts.at_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

### hdl/dim_datapath.sv
// interval storage (two banks, one read and one write port), scan pointers,
// merge compare logic and result registers; depends on dim_pkg
module dim_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dim_pkg::dim_cmd_t                cmd,
  input  logic [dim_pkg::VALUE_BITS-1:0]   in_value,
  output dim_pkg::dim_sts_t                sts,
  output logic                             out_valid,
  output logic [dim_pkg::VALUE_BITS-1:0]   out_range_low,
  output logic [dim_pkg::VALUE_BITS-1:0]   out_range_high,
  output logic                             out_last,
  output logic [dim_pkg::TOTAL_W-1:0]      out_interval_total,
  output logic                             out_dropped,
  output logic                             out_empty_res
);
  import dim_pkg::*;

  typedef struct packed {
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
  } entry_t;

  entry_t mem [MEM_DEPTH];

  logic                  bank_r, bank_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      rd_idx_r, rd_addr_nxt;
  logic [CNT_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [VALUE_BITS-1:0] value_r, lo_r, hi_r, lo_nxt, hi_nxt;
  logic                  placed_r, placed_nxt;
  entry_t                rd_data_r;

  logic                  wr_req, wr_en;
  entry_t                wr_data;
  logic [CNT_W-1:0]      new_count;
  logic [VALUE_BITS:0]   end_inc, val_inc;
  logic                  below, touch;

  logic                  res_valid;
  entry_t                res_range;
  logic                  res_last, res_dropped, res_empty;
  logic [CNT_W-1:0]      res_total;

  logic                  out_valid_r;
  entry_t                out_range_r;
  logic                  out_last_r, out_dropped_r, out_empty_r;
  logic [TOTAL_W-1:0]    out_total_r;

  assign end_inc   = {1'b0, rd_data_r.hi} + 1'b1;
  assign val_inc   = {1'b0, value_r} + 1'b1;
  assign below     = end_inc < {1'b0, value_r};
  assign touch     = {1'b0, rd_data_r.lo} <= val_inc;
  assign new_count = wr_ptr_r + CNT_W'(!placed_r);

  always_comb begin
    bank_nxt    = bank_r;
    count_nxt   = count_r;
    rd_addr_nxt = rd_idx_r;
    wr_ptr_nxt  = wr_ptr_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    placed_nxt  = placed_r;
    wr_req      = 1'b0;
    wr_data     = rd_data_r;
    res_valid   = 1'b0;
    res_range   = '0;
    res_last    = 1'b0;
    res_dropped = 1'b0;
    res_empty   = 1'b0;
    res_total   = count_r;

    if (cmd.load) begin
      rd_addr_nxt = '0;
      wr_ptr_nxt  = '0;
      lo_nxt      = in_value;
      hi_nxt      = in_value;
      placed_nxt  = 1'b0;
    end

    if (cmd.add_step) begin
      if (placed_r || below) begin
        wr_req      = 1'b1;
        wr_ptr_nxt  = wr_ptr_r + CNT_W'(1);
        rd_addr_nxt = rd_idx_r + CNT_W'(1);
      end else if (touch) begin
        if (rd_data_r.lo < lo_r) begin
          lo_nxt = rd_data_r.lo;
        end
        if (rd_data_r.hi > hi_r) begin
          hi_nxt = rd_data_r.hi;
        end
        rd_addr_nxt = rd_idx_r + CNT_W'(1);
      end else begin
        // merged interval goes in ahead of the current entry
        wr_req     = 1'b1;
        wr_data    = '{lo: lo_r, hi: hi_r};
        wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
        placed_nxt = 1'b1;
      end
    end

    if (cmd.add_finish) begin
      res_valid = 1'b1;
      res_last  = 1'b1;
      if (!placed_r) begin
        wr_req  = 1'b1;
        wr_data = '{lo: lo_r, hi: hi_r};
      end
      if (new_count > CNT_W'(MAX_RANGES)) begin
        res_dropped = 1'b1;
      end else begin
        res_range = '{lo: lo_r, hi: hi_r};
        res_total = new_count;
        bank_nxt  = ~bank_r;
        count_nxt = new_count;
      end
    end

    if (cmd.list_step) begin
      res_valid   = 1'b1;
      res_range   = rd_data_r;
      res_last    = sts.at_last;
      rd_addr_nxt = rd_idx_r + CNT_W'(1);
    end

    if (cmd.list_empty) begin
      res_valid = 1'b1;
      res_last  = 1'b1;
      res_empty = 1'b1;
    end
  end

  assign wr_en = wr_req && (wr_ptr_r < CNT_W'(MAX_RANGES));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{~bank_r, wr_ptr_r[IDX_W-1:0]}] <= wr_data;
    end
    rd_data_r <= mem[{bank_r, rd_addr_nxt[IDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= 1'b0;
      count_r     <= '0;
      rd_idx_r    <= '0;
      wr_ptr_r    <= '0;
      placed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bank_r      <= bank_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_addr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      placed_r    <= placed_nxt;
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (res_valid) begin
      out_range_r   <= res_range;
      out_last_r    <= res_last;
      out_dropped_r <= res_dropped;
      out_empty_r   <= res_empty;
      out_total_r   <= TOTAL_W'(res_total);
    end
  end

  assign sts.at_end  = (rd_idx_r == count_r);
  assign sts.at_last = ((rd_idx_r + CNT_W'(1)) == count_r);
  assign sts.empty   = (count_r == '0);

  assign out_valid          = out_valid_r;
  assign out_range_low      = out_range_r.lo;
  assign out_range_high     = out_range_r.hi;
  assign out_last           = out_last_r;
  assign out_interval_total = out_total_r;
  assign out_dropped        = out_dropped_r;
  assign out_empty_res      = out_empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RANGES))
    else $error("interval count above capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.add_step || cmd.list_step) |-> rd_idx_r < count_r)
    else $error("scan index past stored intervals");

  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_finish |=> out_valid && out_last && !out_empty_res)
    else $error("add finish without final result");

  a_list_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.list_step || cmd.list_empty) |-> !wr_en && $stable(bank_r))
    else $error("table modified during list");

endmodule

### hdl/disjoint_interval_merge_table.sv
// top level of the disjoint interval merge table
// instantiates dim_ctrl and dim_datapath; depends on dim_pkg
//
// usage:
//   an item is transferred at a clock edge with start high and busy low.
//   in_func 0 adds in_value to the table, merging every interval that holds
//   or touches it; in_func 1 lists all stored intervals in ascending order.
//   results appear on the out_ ports for one cycle each, marked by out_valid;
//   the receiver cannot stall them. out_last marks the final result.
// scan and results:
//   add: the result follows a one-entry-per-cycle scan through the table
//   memory, with one extra step when the new interval goes in ahead of a
//   stored one.
//   list: after the transfer, results come one per cycle; an empty
//   table gives one result with out_empty_res set.
//   busy drops on the cycle the final result is shown, so a new item can be
//   transferred while that result is on the ports.
// reset: synchronous, active low; the table is empty after reset.
module disjoint_interval_merge_table (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_func,
  input  logic [dim_pkg::VALUE_BITS-1:0]   in_value,
  output logic                             out_valid,
  output logic [dim_pkg::VALUE_BITS-1:0]   out_range_low,
  output logic [dim_pkg::VALUE_BITS-1:0]   out_range_high,
  output logic                             out_last,
  output logic [dim_pkg::TOTAL_W-1:0]      out_interval_total,
  output logic                             out_dropped,
  output logic                             out_empty_res
);
  import dim_pkg::*;

  dim_cmd_t cmd;
  dim_sts_t sts;

  dim_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  dim_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_value           (in_value),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_range_low      (out_range_low),
    .out_range_high     (out_range_high),
    .out_last           (out_last),
    .out_interval_total (out_interval_total),
    .out_dropped        (out_dropped),
    .out_empty_res      (out_empty_res)
  );

endmodule

### tb/sv/dim_merge_checker.sv
// operation codes shared by the testbench files, and the checker that
// predicts and compares every result of disjoint_interval_merge_table
// depends on dim_pkg
package dim_tb_pkg;

  typedef enum logic {
    FUNC_ADD  = 1'b0,
    FUNC_LIST = 1'b1
  } func_t;

endpackage

module dim_merge_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           in_func,
  input  logic [dim_pkg::VALUE_BITS-1:0] in_value,
  input  logic                           out_valid,
  input  logic [dim_pkg::VALUE_BITS-1:0] out_range_low,
  input  logic [dim_pkg::VALUE_BITS-1:0] out_range_high,
  input  logic                           out_last,
  input  logic [dim_pkg::TOTAL_W-1:0]    out_interval_total,
  input  logic                           out_dropped,
  input  logic                           out_empty_res,
  output int                             err_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import dim_pkg::*;
  import dim_tb_pkg::*;

  typedef struct packed {
    logic [VALUE_BITS-1:0] range_low;
    logic [VALUE_BITS-1:0] range_high;
    logic                  last;
    logic [TOTAL_W-1:0]    total;
    logic                  dropped;
    logic                  empty_res;
  } interval_result_t;

  interval_result_t      interval_q[$];
  logic [VALUE_BITS-1:0] low_tab[MAX_RANGES];
  logic [VALUE_BITS-1:0] high_tab[MAX_RANGES];
  int                    held_cnt = 0;
  int                    mismatch_cnt = 0;

  initial begin
    err_count = 0;
    pending   = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < 100) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic string show(input interval_result_t r);
    return $sformatf("low=%h high=%h last=%b total=%0d dropped=%b empty=%b",
                     r.range_low, r.range_high, r.last, r.total, r.dropped,
                     r.empty_res);
  endfunction

  function automatic interval_result_t insert_value(input logic [VALUE_BITS-1:0] v);
    int                    first;
    int                    after;
    int                    merged;
    int                    grown;
    int                    i;
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
    interval_result_t      r;
    first = 0;
    lo    = v;
    hi    = v;
    r     = '0;
    r.last = 1'b1;
    while (first < held_cnt && int'(high_tab[first]) + 1 < int'(v)) first++;
    after = first;
    while (after < held_cnt && int'(low_tab[after]) <= int'(v) + 1) begin
      if (low_tab[after] < lo) lo = low_tab[after];
      if (high_tab[after] > hi) hi = high_tab[after];
      after++;
    end
    merged = after - first;
    grown  = held_cnt - merged + 1;
    if (grown > MAX_RANGES) begin
      r.dropped = 1'b1;
      r.total   = TOTAL_W'(held_cnt);
      return r;
    end
    if (merged == 0) begin
      for (i = held_cnt; i > first; i--) begin
        low_tab[i]  = low_tab[i-1];
        high_tab[i] = high_tab[i-1];
      end
    end else if (merged > 1) begin
      for (i = 0; i < held_cnt - after; i++) begin
        low_tab[first+1+i]  = low_tab[after+i];
        high_tab[first+1+i] = high_tab[after+i];
      end
    end
    low_tab[first]  = lo;
    high_tab[first] = hi;
    held_cnt        = grown;
    r.range_low     = lo;
    r.range_high    = hi;
    r.total         = TOTAL_W'(grown);
    return r;
  endfunction

  task automatic list_intervals();
    interval_result_t r;
    int               i;
    if (held_cnt == 0) begin
      r           = '0;
      r.last      = 1'b1;
      r.empty_res = 1'b1;
      interval_q.insert(interval_q.size(), r);
    end else begin
      for (i = 0; i < held_cnt; i++) begin
        r            = '0;
        r.range_low  = low_tab[i];
        r.range_high = high_tab[i];
        r.last       = (i == held_cnt - 1);
        r.total      = TOTAL_W'(held_cnt);
        interval_q.insert(interval_q.size(), r);
      end
    end
  endtask

  always @(posedge clk) begin
    interval_result_t got;
    interval_result_t want;
    if (!rst_n) begin
      held_cnt = 0;
      interval_q.delete();
    end else begin
      if (out_valid) begin
        got = {out_range_low, out_range_high, out_last, out_interval_total,
               out_dropped, out_empty_res};
        if (interval_q.size() == 0) begin
          report_mismatch({"result with nothing expected: ", show(got)});
        end else begin
          want = interval_q.pop_front();
          if (got !== want)
            report_mismatch({"expected ", show(want), " got ", show(got)});
        end
      end
      if (start && !busy) begin
        if (in_func == FUNC_LIST) list_intervals();
        else interval_q.insert(interval_q.size(), insert_value(in_value));
      end
    end
    pending   <= interval_q.size();
    err_count <= mismatch_cnt;
  end

endmodule

### tb/sv/tb_disjoint_interval_merge_table.sv
// stimulus and verdict for disjoint_interval_merge_table: directed adds and
// lists, windowed fill and merge sweeps, then random values
// depends on dim_pkg, dim_tb_pkg and dim_merge_checker
module tb_disjoint_interval_merge_table;
  timeunit 1ns;
  timeprecision 1ps;

  import dim_pkg::*;
  import dim_tb_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int WINDOW_SPAN = 80;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  start    = 1'b0;
  logic                  in_func  = 1'b0;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  busy;
  logic                  out_valid;
  logic [VALUE_BITS-1:0] out_range_low;
  logic [VALUE_BITS-1:0] out_range_high;
  logic                  out_last;
  logic [TOTAL_W-1:0]    out_interval_total;
  logic                  out_dropped;
  logic                  out_empty_res;
  int                    mismatch_total;
  int                    expect_depth;
  int                    quiet_cycles = 0;
  bit                    idle_on = 1'b1;

  always #4 clk = ~clk;

  disjoint_interval_merge_table u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_range_low      (out_range_low),
    .out_range_high     (out_range_high),
    .out_last           (out_last),
    .out_interval_total (out_interval_total),
    .out_dropped        (out_dropped),
    .out_empty_res      (out_empty_res)
  );

  dim_merge_checker u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_range_low      (out_range_low),
    .out_range_high     (out_range_high),
    .out_last           (out_last),
    .out_interval_total (out_interval_total),
    .out_dropped        (out_dropped),
    .out_empty_res      (out_empty_res),
    .err_count          (mismatch_total),
    .pending            (expect_depth)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(input func_t op, input logic [VALUE_BITS-1:0] v);
    int gap;
    @(negedge clk);
    start    <= 1'b1;
    in_func  <= op;
    in_value <= v;
    forever begin
      @(posedge clk);
      if (!busy) break;
      if (idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 4);
        repeat (gap) begin
          @(negedge clk);
          start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
      end
    end
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  // mostly even offsets: isolated intervals that fill the table
  task automatic fill_window(input int base);
    int pick;
    repeat (48) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        send_item(FUNC_LIST, VALUE_BITS'($urandom));
      else if (pick == 1)
        send_item(FUNC_ADD, VALUE_BITS'(base + 2 * $urandom_range(0, WINDOW_SPAN/2 - 1) + 1));
      else
        send_item(FUNC_ADD, VALUE_BITS'(base + 2 * $urandom_range(0, WINDOW_SPAN/2)));
    end
    send_item(FUNC_LIST, VALUE_BITS'($urandom));
  endtask

  // every value of the window in shuffled order, collapsing it by merges
  task automatic sweep_window(input int base);
    int order[$];
    int k;
    int j;
    int tmp;
    for (k = 0; k <= WINDOW_SPAN; k++) order.insert(order.size(), base + k);
    for (k = WINDOW_SPAN; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) begin
      if ($urandom_range(0, 15) == 0) send_item(FUNC_LIST, VALUE_BITS'($urandom));
      send_item(FUNC_ADD, VALUE_BITS'(order[k]));
    end
    send_item(FUNC_LIST, VALUE_BITS'($urandom));
  endtask

  initial begin
    int pick;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(FUNC_LIST, 16'hffff);
    send_item(FUNC_ADD, 16'h0000);
    send_item(FUNC_ADD, 16'hffff);
    send_item(FUNC_ADD, 16'hffff);
    send_item(FUNC_ADD, 16'h0002);
    send_item(FUNC_ADD, 16'h0001);
    send_item(FUNC_ADD, 16'hfffd);
    send_item(FUNC_ADD, 16'hfffe);
    send_item(FUNC_ADD, 16'h5555);
    send_item(FUNC_ADD, 16'haaaa);
    send_item(FUNC_ADD, 16'h5556);
    send_item(FUNC_ADD, 16'h5554);
    send_item(FUNC_LIST, 16'h0000);
    send_item(FUNC_ADD, 16'h0001);

    pick = $urandom_range(16, 30000);
    fill_window(pick);
    sweep_window(pick);
    fill_window((1 << VALUE_BITS) - 1 - WINDOW_SPAN);
    sweep_window((1 << VALUE_BITS) - 1 - WINDOW_SPAN);

    idle_on = 1'b0;
    repeat (60) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) send_item(FUNC_LIST, VALUE_BITS'($urandom));
      else send_item(FUNC_ADD, VALUE_BITS'($urandom));
    end
    send_item(FUNC_LIST, VALUE_BITS'($urandom));
    @(negedge clk);
    start <= 1'b0;

    while (expect_depth != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### disjoint_interval_merge_table.f
hdl/dim_pkg.sv
hdl/dim_ctrl.sv
hdl/dim_datapath.sv
hdl/disjoint_interval_merge_table.sv
tb/sv/dim_merge_checker.sv
tb/sv/tb_disjoint_interval_merge_table.sv
